// ===== sv/mtms_pkg.sv =====
package mtms_pkg;

  // Storage sizes
  localparam int MAX_TAGS      = 16;
  localparam int MAX_TAG_BYTES = 8;
  localparam int OFFSET_BITS   = 16;

  localparam int TAG_IDX_W = (MAX_TAGS > 1) ? $clog2(MAX_TAGS) : 1;
  localparam int WIN_IDX_W = (MAX_TAG_BYTES > 1) ? $clog2(MAX_TAG_BYTES) : 1;

  // Fixed field widths of the channels and registers
  localparam int BYTE_W    = 8;
  localparam int SEL_W     = 4;
  localparam int POS_W     = 3;
  localparam int CNT_W     = 5;
  localparam int LEN_W     = 4;
  localparam int SKIP_W    = 16;
  localparam int OUT_OFS_W = 16;
  localparam int OUT_TAG_W = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  // Skip check is done one bit wider than the wider of the offset and skip widths
  localparam int CMP_W = ((OFFSET_BITS > SKIP_W) ? OFFSET_BITS : SKIP_W) + 1;

  // Queue between front and back end
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  typedef enum logic [1:0] {
    OP_DATA = 2'd0,
    OP_LOAD = 2'd1,
    OP_DROP = 2'd2
  } op_kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TAG_COUNT   = 2'd0,
    REG_TAG_LENGTH  = 2'd1,
    REG_SKIP_LENGTH = 2'd2
  } reg_idx_e;

  typedef struct packed {
    op_kind_e          kind;
    logic              last;
    logic [BYTE_W-1:0] data;
    logic [SEL_W-1:0]  sel;
    logic [POS_W-1:0]  pos;
  } op_t;

  typedef struct packed {
    logic [CNT_W-1:0]  tag_count;
    logic [LEN_W-1:0]  tag_length;
    logic [SKIP_W-1:0] skip_length;
  } cfg_t;

endpackage

// ===== sv/mtms_in_if.sv =====
interface mtms_in_if;
  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic [mtms_pkg::BYTE_W-1:0]  data_byte;
  logic                         last_byte;
  logic [mtms_pkg::SEL_W-1:0]   tag_select;
  logic [mtms_pkg::POS_W-1:0]   tag_byte_pos;

  modport source (
    output valid, req_type, data_byte, last_byte, tag_select, tag_byte_pos,
    input  ready
  );
  modport sink (
    input  valid, req_type, data_byte, last_byte, tag_select, tag_byte_pos,
    output ready
  );
endinterface

// ===== sv/mtms_out_if.sv =====
interface mtms_out_if;
  logic                            valid;
  logic                            ready;
  logic                            found;
  logic [mtms_pkg::OUT_OFS_W-1:0]  match_offset;
  logic [mtms_pkg::OUT_TAG_W-1:0]  which_tag;

  modport source (
    output valid, found, match_offset, which_tag,
    input  ready
  );
  modport sink (
    input  valid, found, match_offset, which_tag,
    output ready
  );
endinterface

// ===== sv/mtms_front.sv =====
module mtms_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  mtms_in_if.sink         src_i,
  output mtms_pkg::op_t   op_o,
  output logic            op_valid_o,
  input  logic            op_pop_i
);

  mtms_pkg::op_t                   op_q [mtms_pkg::QUEUE_DEPTH];
  mtms_pkg::op_t                   op_cls;
  logic [mtms_pkg::QPTR_W-1:0]     wr_q, wr_d, rd_q, rd_d;
  logic [mtms_pkg::QCNT_W-1:0]     cnt_q, cnt_d;
  logic                            push;

  assign src_i.ready = (cnt_q != mtms_pkg::QCNT_W'(mtms_pkg::QUEUE_DEPTH));
  assign push        = src_i.valid && src_i.ready;

  // Sort the beat: buffer byte, tag load, or a load that addresses no entry
  always_comb begin
    op_cls.last = src_i.last_byte;
    op_cls.data = src_i.data_byte;
    op_cls.sel  = src_i.tag_select;
    op_cls.pos  = src_i.tag_byte_pos;
    if (!src_i.req_type) begin
      op_cls.kind = mtms_pkg::OP_DATA;
    end else if ((int'(src_i.tag_select) < mtms_pkg::MAX_TAGS) &&
                 (int'(src_i.tag_byte_pos) < mtms_pkg::MAX_TAG_BYTES)) begin
      op_cls.kind = mtms_pkg::OP_LOAD;
    end else begin
      op_cls.kind = mtms_pkg::OP_DROP;
    end
  end

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = wr_q + 1'b1;
    end
    if (op_pop_i) begin
      rd_d = rd_q + 1'b1;
    end
    if (push && !op_pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push && op_pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      op_q[wr_q] <= op_cls;
    end
  end

  assign op_o       = op_q[rd_q];
  assign op_valid_o = (cnt_q != '0);

endmodule

// ===== sv/mtms_back.sv =====
module mtms_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mtms_pkg::op_t   op_i,
  input  logic            op_valid_i,
  output logic            op_pop_o,
  input  mtms_pkg::cfg_t  cfg_i,
  mtms_out_if.source      res_o
);

  localparam int TB = mtms_pkg::MAX_TAG_BYTES;
  localparam int NT = mtms_pkg::MAX_TAGS;
  localparam int OB = mtms_pkg::OFFSET_BITS;

  logic [mtms_pkg::BYTE_W-1:0]    tag_q   [NT][TB];
  logic [mtms_pkg::BYTE_W-1:0]    win_q   [TB];
  logic [mtms_pkg::BYTE_W-1:0]    win_d   [TB];
  logic [mtms_pkg::BYTE_W-1:0]    aligned [TB];
  logic [OB-1:0]                  pos_q, pos_d;
  logic                           seen_q, seen_d;
  logic [OB-1:0]                  first_q, first_d;
  logic [mtms_pkg::TAG_IDX_W-1:0] ftag_q, ftag_d;
  logic                           out_vld_q, out_vld_d;
  logic                           found_q;
  logic [mtms_pkg::OUT_OFS_W-1:0] offset_q;
  logic [mtms_pkg::OUT_TAG_W-1:0] which_q;

  logic [mtms_pkg::LEN_W-1:0]     len_eff;
  logic [mtms_pkg::CNT_W-1:0]     cnt_eff;
  logic [NT-1:0]                  hit;
  logic                           any_hit;
  logic [mtms_pkg::TAG_IDX_W-1:0] hit_idx;
  logic [OB:0]                    here_p1;
  logic                           ok;
  logic                           can_emit, is_data, is_load, is_last;

  assign is_data  = (op_i.kind == mtms_pkg::OP_DATA);
  assign is_load  = (op_i.kind == mtms_pkg::OP_LOAD);
  assign is_last  = is_data && op_i.last;
  assign can_emit = !out_vld_q || res_o.ready;
  assign op_pop_o = op_valid_i && (!is_last || can_emit);

  always_comb begin
    if (cfg_i.tag_length == '0) begin
      len_eff = mtms_pkg::LEN_W'(1);
    end else if (int'(cfg_i.tag_length) > TB) begin
      len_eff = mtms_pkg::LEN_W'(TB);
    end else begin
      len_eff = cfg_i.tag_length;
    end
    if (int'(cfg_i.tag_count) > NT) begin
      cnt_eff = mtms_pkg::CNT_W'(NT);
    end else begin
      cnt_eff = cfg_i.tag_count;
    end
  end

  // Window after this byte shifts in; index 0 is the newest byte
  always_comb begin
    win_d[0] = op_i.data;
    for (int k = 1; k < TB; k++) begin
      win_d[k] = win_q[k-1];
    end
  end

  // Tag byte j lines up with window byte len-1-j, same for every tag
  always_comb begin
    for (int j = 0; j < TB; j++) begin
      aligned[j] = '0;
      if (j < int'(len_eff)) begin
        aligned[j] = win_d[mtms_pkg::WIN_IDX_W'(int'(len_eff) - 1 - j)];
      end
    end
  end

  always_comb begin
    for (int t = 0; t < NT; t++) begin
      hit[t] = (t < int'(cnt_eff));
      for (int j = 0; j < TB; j++) begin
        if ((j < int'(len_eff)) && (tag_q[t][j] != aligned[j])) begin
          hit[t] = 1'b0;
        end
      end
    end
  end

  // Lowest tag index wins
  always_comb begin
    any_hit = 1'b0;
    hit_idx = '0;
    for (int t = NT - 1; t >= 0; t--) begin
      if (hit[t]) begin
        any_hit = 1'b1;
        hit_idx = mtms_pkg::TAG_IDX_W'(t);
      end
    end
  end

  assign here_p1 = {1'b0, pos_q} + 1'b1;

  always_comb begin
    seen_d  = seen_q;
    first_d = first_q;
    ftag_d  = ftag_q;
    pos_d   = pos_q;
    if (!seen_q && (here_p1 >= (OB+1)'(len_eff)) && any_hit) begin
      seen_d  = 1'b1;
      first_d = OB'(here_p1 - (OB+1)'(len_eff));
      ftag_d  = hit_idx;
    end
    if (pos_q != '1) begin
      pos_d = pos_q + 1'b1;
    end
    ok = seen_d && ((mtms_pkg::CMP_W'(first_d) + mtms_pkg::CMP_W'(cfg_i.skip_length))
                    <= mtms_pkg::CMP_W'(here_p1));
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (res_o.ready) begin
      out_vld_d = 1'b0;
    end
    if (op_pop_o && is_last) begin
      out_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < TB; k++) begin
        win_q[k] <= '0;
      end
      pos_q     <= '0;
      seen_q    <= 1'b0;
      first_q   <= '0;
      ftag_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
      if (op_pop_o && is_data) begin
        if (op_i.last) begin
          // end of buffer: scan state back to its idle values
          for (int k = 0; k < TB; k++) begin
            win_q[k] <= '0;
          end
          pos_q   <= '0;
          seen_q  <= 1'b0;
          first_q <= '0;
          ftag_q  <= '0;
        end else begin
          win_q   <= win_d;
          pos_q   <= pos_d;
          seen_q  <= seen_d;
          first_q <= first_d;
          ftag_q  <= ftag_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_pop_o && is_load) begin
      tag_q[op_i.sel[mtms_pkg::TAG_IDX_W-1:0]][op_i.pos[mtms_pkg::WIN_IDX_W-1:0]] <= op_i.data;
    end
    if (op_pop_o && is_last) begin
      found_q  <= ok;
      offset_q <= ok ? mtms_pkg::OUT_OFS_W'(first_d) : '0;
      which_q  <= ok ? mtms_pkg::OUT_TAG_W'(ftag_d) : '0;
    end
  end

  assign res_o.valid        = out_vld_q;
  assign res_o.found        = found_q;
  assign res_o.match_offset = offset_q;
  assign res_o.which_tag    = which_q;

endmodule

// ===== sv/multi_tag_marker_search.sv =====
// Marker search: takes one beat per clock while the queue has room, either a
// tag byte load or a buffer byte. Every buffer byte is compared against all
// tags in use at once in the back end, so the sustained rate is one beat per
// cycle unless a beat marked last waits for the result register to be free.
// The result is registered when the back end takes that last beat from the
// queue. A two-entry queue separates intake from the compare stage, and the
// result register lets the next buffer stream in while a result waits. Tag
// bytes must be loaded before any buffer that uses them; the user must write
// registers only while the block is idle, which the block does not enforce.
module multi_tag_marker_search (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  mtms_in_if.sink                          src_i,
  mtms_out_if.source                       res_o,
  input  logic                             cfg_we_i,
  input  logic [mtms_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [mtms_pkg::CFG_DAT_W-1:0]   cfg_data_i
);

  mtms_pkg::cfg_t cfg_q;
  mtms_pkg::op_t  op;
  logic           op_valid;
  logic           op_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tag_count   <= '0;
      cfg_q.tag_length  <= mtms_pkg::LEN_W'(1);
      cfg_q.skip_length <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mtms_pkg::REG_TAG_COUNT: begin
          cfg_q.tag_count <= cfg_data_i[mtms_pkg::CNT_W-1:0];
        end
        mtms_pkg::REG_TAG_LENGTH: begin
          cfg_q.tag_length <= cfg_data_i[mtms_pkg::LEN_W-1:0];
        end
        mtms_pkg::REG_SKIP_LENGTH: begin
          cfg_q.skip_length <= cfg_data_i[mtms_pkg::SKIP_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  mtms_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .src_i      (src_i),
    .op_o       (op),
    .op_valid_o (op_valid),
    .op_pop_i   (op_pop)
  );

  mtms_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (op),
    .op_valid_i (op_valid),
    .op_pop_o   (op_pop),
    .cfg_i      (cfg_q),
    .res_o      (res_o)
  );

endmodule

// ===== verif/multi_tag_marker_search_tb.sv =====
`timescale 1ns / 100ps

module multi_tag_marker_search_tb;

  typedef enum logic {
    REQ_DATA = 1'b0,
    REQ_LOAD = 1'b1
  } req_kind_e;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_HALF,
    RX_SPARSE,
    RX_MOSTLY
  } rx_mode_e;

  localparam int unsigned RANDOM_BEATS  = 1550;
  localparam int unsigned SETTLE_CYCLES = 10;
  localparam int unsigned LONG_HOLD     = 400;
  localparam int unsigned CYCLE_LIMIT   = 2_000_000;

  typedef struct packed {
    req_kind_e                   req_type;
    logic [mtms_pkg::BYTE_W-1:0] data;
    logic                        last;
    logic [mtms_pkg::SEL_W-1:0]  sel;
    logic [mtms_pkg::POS_W-1:0]  pos;
  } beat_t;

  typedef struct packed {
    logic                           found;
    logic [mtms_pkg::OUT_OFS_W-1:0] offset;
    logic [mtms_pkg::OUT_TAG_W-1:0] tag;
  } scan_result_t;

  // Mirrors the search: tag table, byte window, first hit of the current buffer.
  class marker_scoreboard;
    logic [mtms_pkg::BYTE_W-1:0] tag_mem [mtms_pkg::MAX_TAGS][mtms_pkg::MAX_TAG_BYTES];
    logic [mtms_pkg::BYTE_W-1:0] window [mtms_pkg::MAX_TAG_BYTES];
    logic [mtms_pkg::CNT_W-1:0]  tag_count;
    logic [mtms_pkg::LEN_W-1:0]  tag_length;
    logic [mtms_pkg::SKIP_W-1:0] skip_length;
    int unsigned                 byte_pos;
    int unsigned                 hit_offset;
    int unsigned                 hit_tag;
    bit                          hit_seen;
    scan_result_t                scan_results_q[$];
    int unsigned                 errors;

    function new();
      foreach (tag_mem[t, j]) tag_mem[t][j] = '0;
      tag_count   = '0;
      tag_length  = mtms_pkg::LEN_W'(1);
      skip_length = '0;
      errors      = 0;
      clear_scan();
    endfunction

    function void clear_scan();
      foreach (window[k]) window[k] = '0;
      byte_pos   = 0;
      hit_seen   = 1'b0;
      hit_offset = 0;
      hit_tag    = 0;
    endfunction

    function void write_reg(mtms_pkg::reg_idx_e idx, logic [mtms_pkg::CFG_DAT_W-1:0] value);
      case (idx)
        mtms_pkg::REG_TAG_COUNT:   tag_count   = value[mtms_pkg::CNT_W-1:0];
        mtms_pkg::REG_TAG_LENGTH:  tag_length  = value[mtms_pkg::LEN_W-1:0];
        mtms_pkg::REG_SKIP_LENGTH: skip_length = value[mtms_pkg::SKIP_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned active_tags();
      return (tag_count > mtms_pkg::MAX_TAGS) ? mtms_pkg::MAX_TAGS : tag_count;
    endfunction

    function int unsigned active_len();
      if (tag_length == 0) return 1;
      if (tag_length > mtms_pkg::MAX_TAG_BYTES) return mtms_pkg::MAX_TAG_BYTES;
      return tag_length;
    endfunction

    // tag byte 0 is the oldest byte of the window
    function bit tag_in_window(int unsigned t, int unsigned len);
      for (int unsigned j = 0; j < len; j++) begin
        if (tag_mem[t][j] != window[len-1-j]) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_beat(beat_t b);
      int unsigned  len;
      int unsigned  here;
      bit           ok;
      scan_result_t r;
      if (b.req_type == REQ_LOAD) begin
        tag_mem[b.sel][b.pos] = b.data;
        return;
      end
      len = active_len();
      for (int k = mtms_pkg::MAX_TAG_BYTES - 1; k > 0; k--) window[k] = window[k-1];
      window[0] = b.data;
      here = byte_pos;
      if (!hit_seen && here + 1 >= len) begin
        for (int unsigned t = 0; t < active_tags(); t++) begin
          if (tag_in_window(t, len)) begin
            hit_seen   = 1'b1;
            hit_offset = here + 1 - len;
            hit_tag    = t;
            break;
          end
        end
      end
      // position saturates; later bytes reuse it
      if (byte_pos < (1 << mtms_pkg::OFFSET_BITS) - 1) byte_pos++;
      if (!b.last) return;
      ok = hit_seen && (hit_offset + skip_length <= here + 1);
      r.found  = ok;
      r.offset = ok ? hit_offset[mtms_pkg::OUT_OFS_W-1:0] : '0;
      r.tag    = ok ? hit_tag[mtms_pkg::OUT_TAG_W-1:0] : '0;
      scan_results_q.push_back(r);
      clear_scan();
    endfunction

    task report(string msg);
      $display("%0t: mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_result(scan_result_t got);
      scan_result_t want;
      if (scan_results_q.size() == 0) begin
        report($sformatf("result with none pending: found=%0d offset=%0d tag=%0d",
                         got.found, got.offset, got.tag));
        return;
      end
      want = scan_results_q.pop_front();
      if (got.found !== want.found)
        report($sformatf("found %0d, want %0d", got.found, want.found));
      if (got.offset !== want.offset)
        report($sformatf("match_offset %0d, want %0d", got.offset, want.offset));
      if (got.tag !== want.tag)
        report($sformatf("which_tag %0d, want %0d", got.tag, want.tag));
    endtask
  endclass

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [mtms_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [mtms_pkg::CFG_DAT_W-1:0] cfg_data_i;

  mtms_in_if  in_if ();
  mtms_out_if res_if ();

  marker_scoreboard sb;

  int unsigned burst_left;
  int unsigned beats_sent;
  int unsigned cycle_cnt    = 0;
  int unsigned hold_left    = 0;
  int unsigned rx_mode_left = 0;
  int unsigned hold_reqs    = 0;
  int unsigned hold_acks    = 0;
  rx_mode_e    rx_mode      = RX_OPEN;

  multi_tag_marker_search i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .src_i      (in_if),
    .res_o      (res_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result side: checks accepted results, stalls on a pattern of its own
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready)
        sb.check_result({res_if.found, res_if.match_offset, res_if.which_tag});
      if (hold_acks != hold_reqs) begin
        hold_acks = hold_reqs;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        if (rx_mode_left == 0) begin
          rx_mode      = rx_mode_e'($urandom_range(0, 3));
          rx_mode_left = $urandom_range(16, 160);
        end
        rx_mode_left--;
        case (rx_mode)
          RX_OPEN:   res_if.ready <= 1'b1;
          RX_HALF:   res_if.ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: res_if.ready <= ($urandom_range(0, 3) == 0);
          default:   res_if.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  task automatic send_beat(beat_t b);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_if.valid        <= 1'b1;
    in_if.req_type     <= b.req_type;
    in_if.data_byte    <= b.data;
    in_if.last_byte    <= b.last;
    in_if.tag_select   <= b.sel;
    in_if.tag_byte_pos <= b.pos;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_beat(b);
    beats_sent++;
  endtask

  task automatic send_load(int unsigned sel, int unsigned pos,
                           logic [mtms_pkg::BYTE_W-1:0] value, logic last_flag);
    beat_t b;
    b.req_type = REQ_LOAD;
    b.data     = value;
    b.last     = last_flag;
    b.sel      = sel[mtms_pkg::SEL_W-1:0];
    b.pos      = pos[mtms_pkg::POS_W-1:0];
    send_beat(b);
  endtask

  // one buffer; noisy mixes in stray tag loads between its bytes
  task automatic send_buffer(logic [mtms_pkg::BYTE_W-1:0] bytes[$], bit noisy);
    beat_t b;
    foreach (bytes[i]) begin
      if (noisy && $urandom_range(0, 11) == 0)
        send_load($urandom_range(0, mtms_pkg::MAX_TAGS - 1),
                  $urandom_range(0, mtms_pkg::MAX_TAG_BYTES - 1),
                  mtms_pkg::BYTE_W'($urandom()), 1'($urandom_range(0, 1)));
      b.req_type = REQ_DATA;
      b.data     = bytes[i];
      b.last     = (i == bytes.size() - 1);
      b.sel      = mtms_pkg::SEL_W'($urandom());
      b.pos      = mtms_pkg::POS_W'($urandom());
      send_beat(b);
    end
  endtask

  // count and length carry junk above their width
  task automatic apply_config(int unsigned cnt, int unsigned len, int unsigned skip);
    logic [mtms_pkg::CFG_DAT_W-1:0] vals [3];
    mtms_pkg::reg_idx_e             idxs [3];
    vals[0] = mtms_pkg::CFG_DAT_W'($urandom());
    vals[0][mtms_pkg::CNT_W-1:0] = cnt[mtms_pkg::CNT_W-1:0];
    vals[1] = mtms_pkg::CFG_DAT_W'($urandom());
    vals[1][mtms_pkg::LEN_W-1:0] = len[mtms_pkg::LEN_W-1:0];
    vals[2] = skip[mtms_pkg::SKIP_W-1:0];
    idxs = '{mtms_pkg::REG_TAG_COUNT, mtms_pkg::REG_TAG_LENGTH, mtms_pkg::REG_SKIP_LENGTH};
    for (int i = 0; i < 3; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idxs[i];
      cfg_data_i <= vals[i];
      @(posedge clk_i);
      sb.write_reg(idxs[i], vals[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic settle();
    in_if.valid <= 1'b0;
    while (sb.scan_results_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    int unsigned                 phase;
    int unsigned                 n;
    int unsigned                 t;
    int unsigned                 p;
    int unsigned                 a;
    int unsigned                 c;
    int unsigned                 ntags;
    int unsigned                 tlen;
    int unsigned                 start_beats;
    int unsigned                 cnt;
    int unsigned                 len_cfg;
    int unsigned                 skip;
    logic [mtms_pkg::BYTE_W-1:0] scan_bytes[$];

    sb = new();
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = mtms_pkg::REG_TAG_COUNT;
    cfg_data_i         = '0;
    in_if.valid        = 1'b0;
    in_if.req_type     = REQ_DATA;
    in_if.data_byte    = '0;
    in_if.last_byte    = 1'b0;
    in_if.tag_select   = '0;
    in_if.tag_byte_pos = '0;
    burst_left   = 0;
    beats_sent   = 0;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // no tags in use: nothing can match
    apply_config(0, 1, 0);
    scan_bytes = '{8'h00, 8'hFF};
    send_buffer(scan_bytes, 1'b0);

    // fill the whole table before any tag gets compared
    for (t = 0; t < mtms_pkg::MAX_TAGS; t++)
      for (p = 0; p < mtms_pkg::MAX_TAG_BYTES; p++)
        send_load(t, p, mtms_pkg::BYTE_W'($urandom()), 1'($urandom_range(0, 1)));
    send_load(0, 0, 8'h00, 1'b1);
    send_load(mtms_pkg::MAX_TAGS - 1, mtms_pkg::MAX_TAG_BYTES - 1, 8'hFF, 1'b1);
    // tag 7 equals tag 2, so the lower index must win
    for (p = 0; p < mtms_pkg::MAX_TAG_BYTES; p++) send_load(7, p, sb.tag_mem[2][p], 1'b0);
    settle();

    // oversized count and length clamp to the maxima
    apply_config(31, 15, 0);
    scan_bytes = '{8'hFF};
    for (p = 0; p < mtms_pkg::MAX_TAG_BYTES; p++) scan_bytes.push_back(sb.tag_mem[2][p]);
    send_buffer(scan_bytes, 1'b0);
    // buffer shorter than the tag
    scan_bytes.delete();
    for (p = 0; p < 5; p++) scan_bytes.push_back(sb.tag_mem[2][p]);
    send_buffer(scan_bytes, 1'b0);
    settle();

    // zero length acts as one; skip longer than any buffer
    apply_config(16, 0, 16'hFFFF);
    scan_bytes = '{sb.tag_mem[mtms_pkg::MAX_TAGS-1][0]};
    send_buffer(scan_bytes, 1'b0);
    settle();

    // skip exactly fits the buffer
    apply_config(1, 8, 8);
    scan_bytes.delete();
    for (p = 0; p < mtms_pkg::MAX_TAG_BYTES; p++) scan_bytes.push_back(sb.tag_mem[0][p]);
    send_buffer(scan_bytes, 1'b0);

    start_beats = beats_sent;
    phase = 0;
    while (beats_sent - start_beats < RANDOM_BEATS) begin
      phase++;
      settle();
      case ($urandom_range(0, 9))
        0:       cnt = 0;
        1:       cnt = 1;
        2:       cnt = 16;
        3:       cnt = 31;
        4:       cnt = $urandom_range(17, 31);
        default: cnt = $urandom_range(1, 16);
      endcase
      case ($urandom_range(0, 9))
        0:       len_cfg = 0;
        1:       len_cfg = 15;
        2:       len_cfg = $urandom_range(9, 15);
        3:       len_cfg = 1;
        4:       len_cfg = 8;
        default: len_cfg = $urandom_range(1, 8);
      endcase
      case ($urandom_range(0, 9))
        5, 6:    skip = $urandom_range(0, 40);
        7:       skip = 16'hFFFF;
        8:       skip = $urandom();
        9:       skip = $urandom_range(1, 8);
        default: skip = 0;
      endcase
      apply_config(cnt, len_cfg, skip);
      ntags = sb.active_tags();
      tlen  = sb.active_len();

      if (phase == 1) begin
        // result side holds off while short buffers keep coming
        hold_reqs++;
        repeat (30) begin
          scan_bytes.delete();
          repeat ($urandom_range(1, 3)) scan_bytes.push_back(mtms_pkg::BYTE_W'($urandom()));
          send_buffer(scan_bytes, 1'b0);
        end
      end else begin
        if ($urandom_range(0, 3) == 0)
          repeat ($urandom_range(1, 6))
            send_load($urandom_range(0, mtms_pkg::MAX_TAGS - 1),
                      $urandom_range(0, mtms_pkg::MAX_TAG_BYTES - 1),
                      mtms_pkg::BYTE_W'($urandom()), 1'($urandom_range(0, 1)));
        if ($urandom_range(0, 2) == 0) begin
          a = $urandom_range(0, mtms_pkg::MAX_TAGS - 2);
          c = $urandom_range(a + 1, mtms_pkg::MAX_TAGS - 1);
          for (p = 0; p < mtms_pkg::MAX_TAG_BYTES; p++)
            send_load(c, p, sb.tag_mem[a][p], 1'($urandom()));
        end
        repeat ($urandom_range(1, 8)) begin
          case ($urandom_range(0, 19))
            0:             n = $urandom_range(65, 300);
            1, 2, 3, 4, 5: n = $urandom_range(17, 64);
            default:       n = $urandom_range(1, 16);
          endcase
          scan_bytes.delete();
          // drawing from tag bytes gives partial matches and near misses
          if (ntags > 0 && $urandom_range(0, 1) == 1) begin
            repeat (n)
              scan_bytes.push_back(
                sb.tag_mem[$urandom_range(0, ntags - 1)][$urandom_range(0, tlen - 1)]);
          end else begin
            repeat (n) scan_bytes.push_back(mtms_pkg::BYTE_W'($urandom()));
          end
          if (ntags > 0 && n >= tlen && $urandom_range(0, 3) != 0) begin
            t = $urandom_range(0, ntags - 1);
            p = $urandom_range(0, n - tlen);
            for (a = 0; a < tlen; a++) scan_bytes[p + a] = sb.tag_mem[t][a];
          end
          send_buffer(scan_bytes, 1'b1);
        end
      end
    end

    // buffer past the offset limit, match only in the saturated region
    settle();
    apply_config(mtms_pkg::MAX_TAGS, mtms_pkg::MAX_TAG_BYTES, 4);
    scan_bytes.delete();
    n = (1 << mtms_pkg::OFFSET_BITS) + 64;
    repeat (n - mtms_pkg::MAX_TAG_BYTES) scan_bytes.push_back(mtms_pkg::BYTE_W'($urandom()));
    for (p = 0; p < mtms_pkg::MAX_TAG_BYTES; p++) scan_bytes.push_back(sb.tag_mem[9][p]);
    send_buffer(scan_bytes, 1'b0);
    settle();

    if (sb.errors == 0 && sb.scan_results_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/mtms_pkg.sv
sv/mtms_in_if.sv
sv/mtms_out_if.sv
sv/mtms_front.sv
sv/mtms_back.sv
sv/multi_tag_marker_search.sv
verif/multi_tag_marker_search_tb.sv
